@@ rtl/gnt_pkg.sv @@
// ----------------------------------------------------------------------------
// gnt_pkg: shared constants for the gradient noise block
// Opcodes, register indexes, field widths and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none
package gnt_pkg;
  localparam int TableSizeDef    = 256;
  localparam int FractionBitsDef = 16;
  localparam int MaxOctavesDef   = 8;
  localparam int PointW          = 24;
  localparam int GradW           = 16;
  localparam int PermW           = 8;
  localparam int IndexW          = 8;
  localparam int OutW            = 19;
  localparam int CfgAddrW        = 1;
  localparam int CfgDataW        = 4;

  localparam logic OpLoad = 1'b0;
  localparam logic OpEval = 1'b1;

  localparam logic [CfgAddrW-1:0] RegOctaveCount   = 1'd0;
  localparam logic [CfgAddrW-1:0] RegTurbulenceMode = 1'd1;
endpackage
`default_nettype wire

@@ rtl/gradient_noise_turbulence.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_turbulence: 3D gradient noise with turbulence sum
// Input channel (in_valid_i / in_stall_o): one beat is a load or an evaluate.
// A load writes one entry of the gradient table and of the X, Y and Z
// permutation tables and gives no result. An evaluate
// beat gives one noise_value_o beat on the output channel (out_valid_o /
// out_stall_i).
// An evaluate walks the octaves one after another (a single octave with
// turbulence mode off). Each octave computes its smoothstep weights in the
// StSmth and StSmth2 states, issues its eight lattice corners through the
// single read port of each table memory, drains the corner pipe (permutation
// read, gradient read, dot product, weighted term, accumulate) and folds the
// octave into the total in StNext; the result is then posted from StDone.
// The result sits in an output register and the next beat is taken from the
// cycle it appears. While a stalled receiver holds the result, every input
// beat, loads included, waits.
// Reset clears control state and sets the registers (octave_count 7, turbulence
// mode 1); table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
module gradient_noise_turbulence
  import gnt_pkg::*;
#(
  parameter int TABLE_SIZE    = TableSizeDef,
  parameter int FRACTION_BITS = FractionBitsDef,
  parameter int MAX_OCTAVES   = MaxOctavesDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CfgAddrW-1:0]         cfg_index_i,
  input  wire logic [CfgDataW-1:0]         cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        opcode_i,
  input  wire logic [IndexW-1:0]           table_index_i,
  input  wire logic signed [GradW-1:0]     gradient_x_i,
  input  wire logic signed [GradW-1:0]     gradient_y_i,
  input  wire logic signed [GradW-1:0]     gradient_z_i,
  input  wire logic [PermW-1:0]            perm_x_value_i,
  input  wire logic [PermW-1:0]            perm_y_value_i,
  input  wire logic [PermW-1:0]            perm_z_value_i,
  input  wire logic [PointW-1:0]           point_x_i,
  input  wire logic [PointW-1:0]           point_y_i,
  input  wire logic [PointW-1:0]           point_z_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [OutW-1:0]           noise_value_o
);
  localparam int AW   = $clog2(TABLE_SIZE);
  localparam int F    = FRACTION_BITS;
  localparam int OW   = $clog2(MAX_OCTAVES + 1);
  localparam int SW   = F + 2;                 // weights up to 2^F
  localparam int DW   = GradW + F + 4;         // dot product before shift
  localparam int QW   = DW - 15;               // dot in Q.F
  localparam int TW   = SW + QW;               // weight * dot
  localparam int ACCW = TW + 8;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StSmth  = 6'b000010,
    StSmth2 = 6'b000100,
    StWalk  = 6'b001000,
    StNext  = 6'b010000,
    StDone  = 6'b100000
  } state_e;

  // config
  logic [3:0] oct_cnt_q;
  logic       turb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_cnt_q <= 4'd7;
      turb_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegOctaveCount:    oct_cnt_q <= cfg_data_i;
        RegTurbulenceMode: turb_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // memories
  logic [3*GradW-1:0] grad_mem [TABLE_SIZE];
  logic [PermW-1:0]   px_mem   [TABLE_SIZE];
  logic [PermW-1:0]   py_mem   [TABLE_SIZE];
  logic [PermW-1:0]   pz_mem   [TABLE_SIZE];

  state_e state_q, state_d;
  logic in_acc, do_load, do_eval;
  logic out_valid_q;
  logic signed [OutW-1:0] out_q;

  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign do_load = in_acc && (opcode_i == OpLoad);
  assign do_eval = in_acc && (opcode_i == OpEval);

  logic [PointW-1:0] pt_q [3];
  logic [OW-1:0] oct_q, noct_q;
  logic [SW-1:0] w0_q [3], w1_q [3];
  logic [F-1:0] sq_q [3];

  // corner walk: issue counter and pipe valids
  logic [3:0] iss_q;       // corners issued, 8 = done issuing
  logic [2:0] c1_q, c2_q;
  logic v1_q, v2_q, v3_q, v4_q;
  logic [PermW-1:0] rx_q, ry_q, rz_q;
  logic [3*GradW-1:0] rg_q;
  logic signed [ACCW-1:0] oct_sum_q, acc_q;
  logic signed [TW-1:0] term_q;

  logic [AW-1:0] cx, cy, cz;
  logic [2:0] ci;
  assign ci = iss_q[2:0];
  assign cx = AW'(pt_q[0][PointW-1:F]) + AW'(ci[2]);
  assign cy = AW'(pt_q[1][PointW-1:F]) + AW'(ci[1]);
  assign cz = AW'(pt_q[2][PointW-1:F]) + AW'(ci[0]);
  logic issue;
  assign issue = (state_q == StWalk) && !iss_q[3];

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      grad_mem[AW'(table_index_i)] <= {gradient_z_i, gradient_y_i, gradient_x_i};
      px_mem[AW'(table_index_i)]   <= perm_x_value_i;
      py_mem[AW'(table_index_i)]   <= perm_y_value_i;
      pz_mem[AW'(table_index_i)]   <= perm_z_value_i;
    end
    rx_q <= px_mem[cx];
    ry_q <= py_mem[cy];
    rz_q <= pz_mem[cz];
    rg_q <= grad_mem[AW'(rx_q ^ ry_q ^ rz_q)];
  end

  // stage 3: dot product and corner weight (weights precomputed per octave)
  logic [F-1:0] fr [3];
  logic signed [F+1:0] off [3];
  logic signed [DW-1:0] dot;
  logic signed [QW-1:0] dq;
  logic [2*SW-1:0] wxy;
  logic [SW-1:0] wxy_q, wz_q;
  logic signed [QW-1:0] dq_q;
  always_comb begin
    for (int a = 0; a < 3; a++) fr[a] = pt_q[a][F-1:0];
    off[0] = c2_q[2] ? $signed({2'b0, fr[0]}) - $signed((F+2)'(1) <<< F)
                     : $signed({2'b0, fr[0]});
    off[1] = c2_q[1] ? $signed({2'b0, fr[1]}) - $signed((F+2)'(1) <<< F)
                     : $signed({2'b0, fr[1]});
    off[2] = c2_q[0] ? $signed({2'b0, fr[2]}) - $signed((F+2)'(1) <<< F)
                     : $signed({2'b0, fr[2]});
    dot = DW'($signed(rg_q[GradW-1:0]) * off[0])
        + DW'($signed(rg_q[2*GradW-1:GradW]) * off[1])
        + DW'($signed(rg_q[3*GradW-1:2*GradW]) * off[2]);
    dq  = QW'(dot >>> 15);
    wxy = (c2_q[2] ? w1_q[0] : w0_q[0]) * (c2_q[1] ? w1_q[1] : w0_q[1]);
  end

  // weight product stage (second multiply registered apart)
  logic [2*SW-1:0] wt_full;
  assign wt_full = wxy_q * wz_q;

  // smoothstep per axis over the StSmth and StSmth2 states
  logic [2*F-1:0] sqd [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sqd[a] = (2*F)'(pt_q[a][F-1:0]) * (2*F)'(pt_q[a][F-1:0]);
    end
  end

  logic [F+2:0] tmf [3];
  logic [2*F+3:0] smul [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      tmf[a]  = ((F+3)'(3) << F) - ((F+3)'(pt_q[a][F-1:0]) << 1);
      smul[a] = (2*F+4)'(sq_q[a]) * (2*F+4)'(tmf[a]);
    end
  end

  logic [OW-1:0] ncap;
  assign ncap = (int'(oct_cnt_q) > MAX_OCTAVES) ? OW'(MAX_OCTAVES) : OW'(oct_cnt_q);

  logic signed [ACCW-1:0] tot;
  logic signed [ACCW-1:0] rs, ra;
  always_comb begin
    tot = acc_q + (oct_sum_q >>> oct_q);
    rs  = tot >>> (2*F - 16);
    ra  = (turb_q && rs < 0) ? -rs : rs;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (do_eval) state_d = (turb_q && ncap == '0) ? StDone : StSmth;
      StSmth:  state_d = StSmth2;
      StSmth2: state_d = StWalk;
      StWalk:  if (iss_q[3] && !v1_q && !v2_q && !v3_q && !v4_q) state_d = StNext;
      StNext:  state_d = (OW'(oct_q + 1'b1) >= noct_q) ? StDone : StSmth;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
      iss_q <= 4'd0;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == StDone) out_valid_q <= 1'b1;
      if (state_q == StSmth2) iss_q <= 4'd0;
      else if (issue) iss_q <= iss_q + 4'd1;
      v1_q <= issue; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q <= ci; c2_q <= c1_q;
    dq_q  <= dq;
    wxy_q <= SW'(wxy >> F);
    wz_q  <= c2_q[0] ? w1_q[2] : w0_q[2];
    term_q <= TW'($signed({1'b0, SW'(wt_full >> F)}) * dq_q);
    if (v4_q) oct_sum_q <= oct_sum_q + ACCW'(term_q);
    case (state_q)
      StIdle: if (do_eval) begin
        pt_q[0] <= point_x_i; pt_q[1] <= point_y_i; pt_q[2] <= point_z_i;
        oct_q <= '0;
        noct_q <= turb_q ? ncap : OW'(1);
        acc_q <= '0;
        oct_sum_q <= '0;
      end
      StSmth: for (int a = 0; a < 3; a++) sq_q[a] <= sqd[a][2*F-1:F];
      StSmth2: for (int a = 0; a < 3; a++) begin
        w1_q[a] <= SW'(smul[a] >> F);
        w0_q[a] <= SW'((SW+1)'(1) << F) - SW'(smul[a] >> F);
      end
      StNext: begin
        acc_q <= tot;
        oct_sum_q <= '0;
        oct_q <= oct_q + 1'b1;
        for (int a = 0; a < 3; a++) pt_q[a] <= {pt_q[a][PointW-2:0], 1'b0};
      end
      StDone: begin
        if (ra > ACCW'(262143)) out_q <= OutW'(262143);
        else if (ra < -ACCW'(262144)) out_q <= OutW'(-262144);
        else out_q <= OutW'(ra);
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = out_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("beat taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(noise_value_o)))
    else $error("result dropped under stall");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> out_valid_o) else $error("result not posted");
endmodule
`default_nettype wire

@@ dv/gradient_noise_turbulence_tb.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_turbulence_tb: self-checking bench for the gradient noise block
// Loads the permutation and gradient tables, then evaluates directed and random
// points under several octave and mode settings. Each noise result is compared
// with a bit-accurate fixed-point prediction held in a small scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none
module gradient_noise_turbulence_tb;
  import gnt_pkg::*;

  localparam int Frac = FractionBitsDef;

  int unsigned err_cnt = 0;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    err_cnt++;
  endtask

  class noise_board;
    logic signed [GradW-1:0] grad [256][3];
    logic [PermW-1:0] perm [3][256];
    int unsigned octaves = 7;
    bit turb = 1;
    logic signed [OutW-1:0] pending [$];

    function longint floor_div(longint x, int n);
      return x >>> n;
    endfunction

    function longint octave_sum(longint p [3]);
      longint one, lat [3], fr [3], sq, sw, wsel [3][2], offs [3][2], sum, dot, wt;
      int h;
      one = longint'(1) << Frac;
      sum = 0;
      for (int ax = 0; ax < 3; ax++) begin
        lat[ax] = p[ax] >> Frac;
        fr[ax] = p[ax] & (one - 1);
        sq = (fr[ax] * fr[ax]) >> Frac;
        sw = (sq * (3 * one - 2 * fr[ax])) >> Frac;
        wsel[ax][0] = one - sw;
        wsel[ax][1] = sw;
        offs[ax][0] = fr[ax];
        offs[ax][1] = fr[ax] - one;
      end
      for (int a = 0; a < 2; a++)
        for (int b = 0; b < 2; b++)
          for (int c = 0; c < 2; c++) begin
            h = perm[0][(lat[0] + a) % 256] ^ perm[1][(lat[1] + b) % 256]
              ^ perm[2][(lat[2] + c) % 256];
            dot = longint'(grad[h][0]) * offs[0][a] + longint'(grad[h][1]) * offs[1][b]
                + longint'(grad[h][2]) * offs[2][c];
            wt = (wsel[0][a] * wsel[1][b]) >> Frac;
            wt = (wt * wsel[2][c]) >> Frac;
            sum += wt * floor_div(dot, 15);
          end
      return sum;
    endfunction

    function void note_beat(bit op, logic [7:0] idx, logic signed [15:0] gx,
                            logic signed [15:0] gy, logic signed [15:0] gz,
                            logic [7:0] px, logic [7:0] py, logic [7:0] pz,
                            logic [23:0] qx, logic [23:0] qy, logic [23:0] qz);
      longint p [3], acc, r;
      int n;
      if (op == OpLoad) begin
        grad[idx][0] = gx; grad[idx][1] = gy; grad[idx][2] = gz;
        perm[0][idx] = px; perm[1][idx] = py; perm[2][idx] = pz;
        return;
      end
      p[0] = qx; p[1] = qy; p[2] = qz;
      acc = 0;
      if (!turb) acc = octave_sum(p);
      else begin
        n = (octaves > MaxOctavesDef) ? MaxOctavesDef : octaves;
        for (int k = 0; k < n; k++) begin
          acc += floor_div(octave_sum(p), k);
          for (int ax = 0; ax < 3; ax++) p[ax] = (p[ax] << 1) & 64'hFFFFFF;
        end
      end
      r = floor_div(acc, 2 * Frac - 16);
      if (turb && r < 0) r = -r;
      if (r > 262143) r = 262143;
      if (r < -262144) r = -262144;
      pending.push_back(r[OutW-1:0]);
    endfunction

    task check_result(logic signed [OutW-1:0] got);
      logic signed [OutW-1:0] want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected noise_value %0d", got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) report($sformatf("noise_value got %0d want %0d", got, want));
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [CfgAddrW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 1;
  logic opcode = 0;
  logic [IndexW-1:0] table_index = '0;
  logic signed [GradW-1:0] grad_x = '0, grad_y = '0, grad_z = '0;
  logic [PermW-1:0] perm_x = '0, perm_y = '0, perm_z = '0;
  logic [PointW-1:0] pt_x = '0, pt_y = '0, pt_z = '0;
  logic signed [OutW-1:0] noise_value;
  noise_board board = new();

  always #4 clk = ~clk;

  gradient_noise_turbulence dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .table_index_i(table_index), .gradient_x_i(grad_x),
    .gradient_y_i(grad_y), .gradient_z_i(grad_z), .perm_x_value_i(perm_x),
    .perm_y_value_i(perm_y), .perm_z_value_i(perm_z), .point_x_i(pt_x),
    .point_y_i(pt_y), .point_z_i(pt_z), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .noise_value_o(noise_value)
  );

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stall, check every accepted beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(noise_value);
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) hold--;
      else if ($urandom_range(0, 3) == 0) hold = gap_len();
      out_stall <= (hold > 0);
    end
  end

  task automatic send_beat(bit op, logic [7:0] idx, logic signed [15:0] gx,
                           logic signed [15:0] gy, logic signed [15:0] gz,
                           logic [7:0] px, logic [7:0] py, logic [7:0] pz,
                           logic [23:0] qx, logic [23:0] qy, logic [23:0] qz);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op; table_index <= idx;
    grad_x <= gx; grad_y <= gy; grad_z <= gz;
    perm_x <= px; perm_y <= py; perm_z <= pz;
    pt_x <= qx; pt_y <= qy; pt_z <= qz;
    // advance until the beat is taken
    do @(posedge clk); while (in_stall);
    board.note_beat(op, idx, gx, gy, gz, px, py, pz, qx, qy, qz);
  endtask

  task automatic load_entry(logic [7:0] idx, bit extreme);
    logic signed [15:0] g [3];
    for (int i = 0; i < 3; i++)
      g[i] = extreme ? ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000) : 16'($urandom);
    send_beat(OpLoad, idx, g[0], g[1], g[2], 8'($urandom), 8'($urandom), 8'($urandom),
              24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic eval_point(logic [23:0] qx, logic [23:0] qy, logic [23:0] qz);
    send_beat(OpEval, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom), qx, qy, qz);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == RegOctaveCount) board.octaves = val;
    else board.turb = val[0];
  endtask

  initial begin
    int oct_set [6] = '{1, 8, 0, 15, 3, 7};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // fill every entry so no read ever touches an unloaded slot
    for (int i = 0; i < 256; i++) load_entry(8'(i), (i % 7) == 0);
    // directed: lattice corners, fraction extremes, wrapping coordinates
    eval_point(24'h000000, 24'h000000, 24'h000000);
    eval_point(24'hffffff, 24'hffffff, 24'hffffff);
    eval_point(24'h008000, 24'h00ffff, 24'h000001);
    eval_point(24'hff0000, 24'h800000, 24'h7fffff);
    eval_point(24'h123456, 24'hfedcba, 24'h00ff00);
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      write_reg(RegTurbulenceMode, (ph % 4 == 3) ? 4'd0 : 4'd1);
      write_reg(RegOctaveCount, 4'(oct_set[ph % 6]));
      if (ph == 0) begin
        eval_point(24'hffffff, 24'h000000, 24'hffffff);
        eval_point(24'h00ffff, 24'hff0001, 24'h800000);
      end
      for (int n = 0; n < 74; n++) begin
        if ($urandom_range(0, 4) == 0) load_entry(8'($urandom), $urandom_range(0, 9) == 0);
        else if ($urandom_range(0, 9) == 0)
          eval_point(24'($urandom_range(0, 1) ? 24'hffffff : 24'h0),
                     24'($urandom), 24'($urandom_range(0, 1) ? 24'h00ffff : 24'h010000));
        else eval_point(24'($urandom), 24'($urandom), 24'($urandom));
      end
    end
    drain();
    if (err_cnt == 0 && board.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/gnt_pkg.sv
rtl/gradient_noise_turbulence.sv
dv/gradient_noise_turbulence_tb.sv
